// ===== rtl/core/u8cp_pkg.sv =====
package u8cp_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;

  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  localparam logic [15:0] HIGH_MAP [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  typedef struct packed {
    logic [7:0] byte_in;
    logic       has_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       fell_back;
    logic       overflowed;
  } out_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic advance;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic run_empty;
    logic at_end;
  } sts_t;

  function automatic logic [7:0] map_code(input logic [20:0] cp);
    logic [7:0] res;
    res = CHAR_QMARK;
    if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
      res = cp[7:0];
    end else begin
      for (int k = 0; k < 32; k++) begin
        if (cp == {5'd0, HIGH_MAP[k]}) begin
          res = 8'(32'h80 + k);
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/u8cp_ctrl.sv =====
module u8cp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  u8cp_pkg::sts_t  sts_i,
  output u8cp_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SHOW  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   in_acc, out_acc;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_SHOW);
  assign in_acc      = in_valid_i && (state_q == ST_LOAD);
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.load    = in_acc;
    cmd_o.fetch   = (state_q == ST_FETCH);
    case (state_q)
      ST_LOAD: begin
        if (in_acc && sts_i.in_last) begin
          if (sts_i.run_empty) begin
            cmd_o.clear = 1'b1;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_acc) begin
          if (sts_i.at_end) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_load_during_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> !cmd_o.load)
    else $error("load issued during run");

  a_clear_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.clear && state_q == ST_SHOW) |=> (state_q == ST_LOAD))
    else $error("run did not end after clear");

  a_show_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> (state_q == ST_SHOW))
    else $error("fetch not followed by show");

endmodule

// ===== rtl/core/u8cp_dp.sv =====
module u8cp_dp #(
  parameter int unsigned MaxLen = u8cp_pkg::MAX_LEN_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u8cp_pkg::cmd_t  cmd_i,
  output u8cp_pkg::sts_t  sts_o,
  input  u8cp_pkg::in_t   in_data_i,
  output u8cp_pkg::out_t  out_data_o
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned IdxW = $clog2(MaxLen);

  logic [7:0] raw_mem  [MaxLen];
  logic [7:0] conv_mem [MaxLen];

  logic [CntW-1:0] raw_cnt_q, raw_cnt_d, conv_cnt_q, conv_cnt_d, run_len;
  logic [20:0]     pc_q, pc_d, pc_next;
  logic [1:0]      pend_q, pend_d;
  logic            err_q, err_d, ov_q, ov_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]      raw_rd_q, conv_rd_q, in_byte, conv_val;
  logic            store_en, conv_push, conv_we, fin_err;

  assign in_byte = in_data_i.byte_in;
  assign pc_next = {pc_q[14:0], in_byte[5:0]};

  always_comb begin
    raw_cnt_d  = raw_cnt_q;
    conv_cnt_d = conv_cnt_q;
    pc_d       = pc_q;
    pend_d     = pend_q;
    err_d      = err_q;
    ov_d       = ov_q;
    rd_idx_d   = rd_idx_q;
    conv_push  = 1'b0;
    conv_val   = in_byte;
    store_en   = cmd_i.load && in_data_i.has_byte && (raw_cnt_q < CntW'(MaxLen));

    if (cmd_i.load && in_data_i.has_byte && !store_en) begin
      ov_d = 1'b1;
    end

    if (store_en) begin
      raw_cnt_d = raw_cnt_q + CntW'(1);
      if (!err_q) begin
        if (pend_q == 2'd0) begin
          if (!in_byte[7]) begin
            conv_push = 1'b1;
          end else if (in_byte[7:5] == 3'b110) begin
            pc_d   = 21'(in_byte[4:0]);
            pend_d = 2'd1;
          end else if (in_byte[7:4] == 4'b1110) begin
            pc_d   = 21'(in_byte[3:0]);
            pend_d = 2'd2;
          end else if (in_byte[7:3] == 5'b11110) begin
            pc_d   = 21'(in_byte[2:0]);
            pend_d = 2'd3;
          end else begin
            err_d = 1'b1;
          end
        end else if (in_byte[7:6] != 2'b10) begin
          err_d = 1'b1;
        end else begin
          pc_d   = pc_next;
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            conv_push = 1'b1;
            conv_val  = u8cp_pkg::map_code(pc_next);
          end
        end
      end
    end

    conv_we = conv_push && (conv_cnt_q < CntW'(MaxLen));
    if (conv_we) begin
      conv_cnt_d = conv_cnt_q + CntW'(1);
    end

    fin_err = err_d || (pend_d != 2'd0);
    if (cmd_i.load && in_data_i.is_last) begin
      err_d = fin_err;
    end

    if (cmd_i.advance) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end

    if (cmd_i.clear) begin
      raw_cnt_d  = '0;
      conv_cnt_d = '0;
      pc_d       = '0;
      pend_d     = '0;
      err_d      = 1'b0;
      ov_d       = 1'b0;
      rd_idx_d   = '0;
    end
  end

  assign run_len          = err_q ? raw_cnt_q : conv_cnt_q;
  assign sts_o.in_last    = in_data_i.is_last;
  assign sts_o.run_empty  = fin_err ? ((raw_cnt_q == '0) && !store_en)
                                    : ((conv_cnt_q == '0) && !conv_we);
  assign sts_o.at_end     = ((CntW'(rd_idx_q) + CntW'(1)) == run_len);

  assign out_data_o.out_byte   = err_q ? raw_rd_q : conv_rd_q;
  assign out_data_o.last_out   = sts_o.at_end;
  assign out_data_o.fell_back  = err_q;
  assign out_data_o.overflowed = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_cnt_q  <= '0;
      conv_cnt_q <= '0;
      pc_q       <= '0;
      pend_q     <= '0;
      err_q      <= 1'b0;
      ov_q       <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      raw_cnt_q  <= raw_cnt_d;
      conv_cnt_q <= conv_cnt_d;
      pc_q       <= pc_d;
      pend_q     <= pend_d;
      err_q      <= err_d;
      ov_q       <= ov_d;
      rd_idx_q   <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      raw_mem[raw_cnt_q[IdxW-1:0]] <= in_byte;
    end
    if (cmd_i.fetch) begin
      raw_rd_q <= raw_mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_we) begin
      conv_mem[conv_cnt_q[IdxW-1:0]] <= conv_val;
    end
    if (cmd_i.fetch) begin
      conv_rd_q <= conv_mem[rd_idx_q];
    end
  end

  a_conv_le_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_cnt_q <= raw_cnt_q)
    else $error("converted count exceeds raw count");

  a_raw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_cnt_q <= CntW'(MaxLen))
    else $error("raw count beyond buffer");

  a_fetch_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fetch |-> (CntW'(rd_idx_q) < run_len))
    else $error("fetch beyond run length");

endmodule

// ===== rtl/core/utf8_to_cp1252_converter.sv =====
// UTF-8 to CP1252 string converter. Bytes of a string enter one per cycle
// while no result run is in progress and are decoded as they arrive; both the
// raw bytes and the converted bytes are kept in MAX_LEN-entry buffers, and
// bytes past MAX_LEN are dropped with the overflow flag set. The request that
// carries the last mark starts the result run, during which the input is
// stalled: each result is read from its buffer into a register in the fetch
// state and then presented in the show state, where it is held while the
// output stalls. A string with nothing stored yields no results and the
// block is ready again on the next cycle. No clearing pass follows reset.
module utf8_to_cp1252_converter #(
  parameter int unsigned MAX_LEN = u8cp_pkg::MAX_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  u8cp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output u8cp_pkg::out_t out_data_o
);

  u8cp_pkg::cmd_t cmd;
  u8cp_pkg::sts_t sts;

  u8cp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  u8cp_dp #(
    .MaxLen (MAX_LEN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== dv/tb_utf8_to_cp1252_converter.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_cp1252_converter;

  localparam int unsigned MAX_LEN = u8cp_pkg::MAX_LEN_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 16;

  localparam logic [15:0] WIN_HIGH [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  typedef struct {
    u8cp_pkg::in_t req;
    bit            drain;
  } pend_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  u8cp_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  u8cp_pkg::out_t out_data_o;

  utf8_to_cp1252_converter #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  pend_t          req_q[$];
  u8cp_pkg::out_t expected_out_q[$];
  logic [7:0]     str_q[$];

  logic [7:0]  raw_buf [MAX_LEN];
  logic [7:0]  win_buf [MAX_LEN];
  int unsigned raw_n;
  int unsigned win_n;
  logic [20:0] code_acc = '0;
  logic [1:0]  cont_left = 2'd0;
  bit          bad_seq;
  bit          dropped;

  int unsigned mismatch_cnt;
  int unsigned sent_cnt;
  int unsigned string_cnt;
  int unsigned rx_cnt;
  int unsigned fallback_cnt;
  int unsigned overflow_cnt;
  int unsigned cycle_cnt;
  int unsigned stim_bytes;

  int unsigned tx_wait;
  bit          tx_idle;
  bit          tx_busy;
  pend_t       tx_next;

  int unsigned rx_wait;
  int unsigned hold_left;
  bit          hold_done;
  bit          rx_idle;
  bit          rx_took;
  bit          stall_next;

  function automatic logic [7:0] cp1252_of(logic [20:0] cp);
    logic [7:0] b;
    b = u8cp_pkg::CHAR_QMARK;
    if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
      b = cp[7:0];
    end else begin
      for (int k = 0; k < 32; k++) begin
        if (cp == 21'(WIN_HIGH[k])) begin
          b = 8'h80 + 8'(k);
        end
      end
    end
    return b;
  endfunction

  task automatic convert_request(u8cp_pkg::in_t r);
    int unsigned n;
    logic [7:0] c;
    u8cp_pkg::out_t o;
    c = r.byte_in;
    if (r.has_byte) begin
      if (raw_n < MAX_LEN) begin
        raw_buf[raw_n] = c;
        raw_n++;
        if (!bad_seq) begin
          if (cont_left == 2'd0) begin
            if (c < 8'h80) begin
              win_buf[win_n] = c;
              win_n++;
            end else if ((c & 8'hE0) == 8'hC0) begin
              code_acc = 21'(c & 8'h1F);
              cont_left = 2'd1;
            end else if ((c & 8'hF0) == 8'hE0) begin
              code_acc = 21'(c & 8'h0F);
              cont_left = 2'd2;
            end else if ((c & 8'hF8) == 8'hF0) begin
              code_acc = 21'(c & 8'h07);
              cont_left = 2'd3;
            end else begin
              bad_seq = 1'b1;
            end
          end else if ((c & 8'hC0) != 8'h80) begin
            bad_seq = 1'b1;
          end else begin
            code_acc = {code_acc[14:0], c[5:0]};
            cont_left--;
            if (cont_left == 2'd0) begin
              win_buf[win_n] = cp1252_of(code_acc);
              win_n++;
            end
          end
        end
      end else begin
        dropped = 1'b1;
      end
    end
    if (r.is_last) begin
      if (cont_left != 2'd0) bad_seq = 1'b1;
      n = bad_seq ? raw_n : win_n;
      for (int unsigned k = 0; k < n; k++) begin
        o.out_byte   = bad_seq ? raw_buf[k] : win_buf[k];
        o.last_out   = (k + 1 == n);
        o.fell_back  = bad_seq;
        o.overflowed = dropped;
        expected_out_q.insert(expected_out_q.size(), o);
      end
      string_cnt++;
      if (bad_seq && n != 0) fallback_cnt++;
      if (dropped && n != 0) overflow_cnt++;
      raw_n = 0;
      win_n = 0;
      code_acc = '0;
      cont_left = 2'd0;
      bad_seq = 1'b0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      tx_busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        convert_request(in_data_i);
        sent_cnt++;
        tx_busy = 1'b0;
        if (sent_cnt % 40 == 0) tx_idle = ($urandom_range(0, 2) == 0);
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() != 0 && !(req_q[0].drain && expected_out_q.size() != 0)) begin
          tx_next = req_q.pop_front();
          in_data_i <= tx_next.req;
          in_valid_i <= 1'b1;
          tx_wait = tx_idle ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_took = out_valid_o && !out_stall_i;
      if (rx_took) begin
        if (expected_out_q.size() == 0) begin
          $error("unexpected result: out_byte %h last_out %b", out_data_o.out_byte,
                 out_data_o.last_out);
          mismatch_cnt++;
        end else begin
          if (out_data_o.out_byte !== expected_out_q[0].out_byte) begin
            $error("out_byte: expected %h, got %h", expected_out_q[0].out_byte,
                   out_data_o.out_byte);
            mismatch_cnt++;
          end
          if (out_data_o.last_out !== expected_out_q[0].last_out) begin
            $error("last_out: expected %b, got %b", expected_out_q[0].last_out,
                   out_data_o.last_out);
            mismatch_cnt++;
          end
          if (out_data_o.fell_back !== expected_out_q[0].fell_back) begin
            $error("fell_back: expected %b, got %b", expected_out_q[0].fell_back,
                   out_data_o.fell_back);
            mismatch_cnt++;
          end
          if (out_data_o.overflowed !== expected_out_q[0].overflowed) begin
            $error("overflowed: expected %b, got %b", expected_out_q[0].overflowed,
                   out_data_o.overflowed);
            mismatch_cnt++;
          end
          void'(expected_out_q.pop_front());
        end
        rx_cnt++;
        rx_wait = rx_idle ? 0 : $urandom_range(0, 4);
        if (rx_cnt % 50 == 0) rx_idle = ($urandom_range(0, 2) == 0);
        if (rx_cnt == 40 && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("utf8_to_cp1252_converter: mismatch");
      $finish;
    end
  end

  task automatic push_req(logic [7:0] b, bit has, bit last, bit drain);
    pend_t p;
    p.req.byte_in  = b;
    p.req.has_byte = has;
    p.req.is_last  = last;
    p.drain        = drain;
    req_q.insert(req_q.size(), p);
  endtask

  task automatic add_byte(logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endtask

  task automatic add_cp(int unsigned cp);
    if (cp < 'h80) begin
      add_byte(8'(cp));
    end else if (cp < 'h800) begin
      add_byte(8'hC0 | 8'(cp >> 6));
      add_byte(8'h80 | 8'(cp & 'h3F));
    end else if (cp < 'h10000) begin
      add_byte(8'hE0 | 8'(cp >> 12));
      add_byte(8'h80 | 8'((cp >> 6) & 'h3F));
      add_byte(8'h80 | 8'(cp & 'h3F));
    end else begin
      add_byte(8'hF0 | 8'(cp >> 18));
      add_byte(8'h80 | 8'((cp >> 12) & 'h3F));
      add_byte(8'h80 | 8'((cp >> 6) & 'h3F));
      add_byte(8'h80 | 8'(cp & 'h3F));
    end
  endtask

  task automatic flush_string(bit drain, bit sep_mark, bit noise);
    bit first;
    first = 1'b1;
    if (str_q.size() == 0) sep_mark = 1'b1;
    foreach (str_q[i]) begin
      if (noise && $urandom_range(0, 9) == 0) begin
        push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, drain && first);
        first = 1'b0;
      end
      push_req(str_q[i], 1'b1, !sep_mark && (i == str_q.size() - 1), drain && first);
      first = 1'b0;
      stim_bytes++;
    end
    if (sep_mark) push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && first);
    str_q.delete();
  endtask

  task automatic add_random_cp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_cp($urandom_range(0, 'h7F));
      4:          add_cp($urandom_range('h80, 'hFF));
      5:          add_cp(WIN_HIGH[$urandom_range(0, 31)]);
      6:          add_cp($urandom_range('h100, 'h7FF));
      7:          add_cp($urandom_range('h800, 'hFFFF));
      8:          add_cp($urandom_range('h10000, 'h1FFFFF));
      default:    add_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    tx_idle = 1'b0;
    rx_idle = 1'b0;

    // ASCII extremes, Latin-1, high table, unmapped four-byte code point
    str_q = '{8'h00, 8'h7F, 8'hC3, 8'hBF, 8'hE2, 8'h82, 8'hAC, 8'hC5, 8'hB8,
              8'hF0, 8'h9F, 8'h98, 8'h80};
    flush_string(1'b0, 1'b0, 1'b0);
    // bad lead bytes, bad continuation, cut-short sequence
    str_q = '{8'h80};
    flush_string(1'b0, 1'b0, 1'b0);
    str_q = '{8'h41, 8'hFF};
    flush_string(1'b0, 1'b0, 1'b0);
    str_q = '{8'hC3, 8'h41};
    flush_string(1'b0, 1'b0, 1'b0);
    str_q = '{8'hE2, 8'h82};
    flush_string(1'b0, 1'b0, 1'b0);
    // empty string, then idle request and a separate end mark
    flush_string(1'b0, 1'b1, 1'b0);
    push_req(8'h00, 1'b0, 1'b0, 1'b0);
    str_q = '{8'h41};
    flush_string(1'b0, 1'b1, 1'b0);

    for (int s = 0; s <= 14 || stim_bytes < 290; s++) begin
      for (int k = $urandom_range(1, 8); k > 0; k--) add_random_cp();
      if (str_q.size() > 1 && $urandom_range(0, 7) == 0) void'(str_q.pop_back());
      if (s == 12) begin
        flush_string(1'b1, 1'b0, 1'b1);
      end else begin
        flush_string(1'b0, $urandom_range(0, 4) == 0, 1'b1);
      end
      if (s == 8) begin
        while (str_q.size() < MAX_LEN) begin
          if (str_q.size() < MAX_LEN - 4) add_random_cp();
          else add_byte(8'($urandom_range(0, 'h7F)));
        end
        flush_string(1'b0, 1'b0, 1'b0);
      end
      if (s == 14) begin
        while (str_q.size() < MAX_LEN + 4) add_random_cp();
        flush_string(1'b1, $urandom_range(0, 1), 1'b0);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || in_valid_i || expected_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d requests in %0d strings, %0d result bytes checked", sent_cnt, string_cnt,
             rx_cnt);
    $display("%0d runs fell back to raw bytes, %0d runs dropped bytes", fallback_cnt,
             overflow_cnt);
    if (mismatch_cnt == 0) begin
      $display("utf8_to_cp1252_converter: match");
    end else begin
      $display("utf8_to_cp1252_converter: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/u8cp_pkg.sv
rtl/core/u8cp_ctrl.sv
rtl/core/u8cp_dp.sv
rtl/core/utf8_to_cp1252_converter.sv
dv/tb_utf8_to_cp1252_converter.sv
